[sv/mdpc_pkg.sv]
// shared types, constants and index helpers for the multi-depth prefix cache
package mdpc_pkg;

  localparam int TABLE2_DEPTH  = 65536;
  localparam int TABLE3_DEPTH  = 4096;
  localparam int TABLE4_DEPTH  = 4096;
  localparam int PAYLOAD_BITS  = 64;
  localparam int ROOT_EPOCHS   = 256;
  localparam int PREFIX_EPOCHS = 65536;

  localparam int T2_AW   = $clog2(TABLE2_DEPTH);
  localparam int T3_AW   = $clog2(TABLE3_DEPTH);
  localparam int T4_AW   = $clog2(TABLE4_DEPTH);
  localparam int ROOT_AW = $clog2(ROOT_EPOCHS);
  localparam int PFX_AW  = $clog2(PREFIX_EPOCHS);

  // operation kinds
  localparam logic [2:0] K_LOOKUP    = 3'd0;
  localparam logic [2:0] K_PUT_ALL   = 3'd1;
  localparam logic [2:0] K_PUT_DEPTH = 3'd2;
  localparam logic [2:0] K_INV_PFX   = 3'd3;
  localparam logic [2:0] K_INV_ROOT  = 3'd4;
  localparam logic [2:0] K_INV_ALL   = 3'd5;
  localparam logic [2:0] K_CLEAR     = 3'd6;

  // register indexes
  localparam logic [2:0] REG_T2_BITS = 3'd0;
  localparam logic [2:0] REG_T3_EN   = 3'd1;
  localparam logic [2:0] REG_T3_BITS = 3'd2;
  localparam logic [2:0] REG_T4_EN   = 3'd3;
  localparam logic [2:0] REG_T4_BITS = 3'd4;

  typedef struct packed {
    logic [4:0] t2_bits;
    logic       t3_en;
    logic [3:0] t3_bits;
    logic       t4_en;
    logic [3:0] t4_bits;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [15:0]       tag;
    logic [1:0]        origin;
    logic [31:0]       epoch;
    logic [PAYLOAD_BITS-1:0] payload;
  } t2_entry_t;

  typedef struct packed {
    logic              valid;
    logic [23:0]       tag;
    logic [1:0]        origin;
    logic [31:0]       epoch;
    logic [PAYLOAD_BITS-1:0] payload;
  } t3_entry_t;

  typedef struct packed {
    logic              valid;
    logic [31:0]       tag;
    logic [1:0]        origin;
    logic [31:0]       epoch;
    logic [PAYLOAD_BITS-1:0] payload;
  } t4_entry_t;

  typedef struct packed {
    logic             load;
    logic             rd;
    logic             eval;
    logic             exec;
    logic             sweep;
    logic             sweep_full;
    logic [T2_AW-1:0] sweep_addr;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
  } stat_t;

  // 2-byte table index mask, bit count clamped to 14..16
  function automatic logic [T2_AW-1:0] mask2(input logic [4:0] bits);
    logic [T2_AW-1:0] m;
    priority if (bits <= 5'd14) m = T2_AW'(16'h3FFF);
    else if (bits == 5'd15)     m = T2_AW'(16'h7FFF);
    else                        m = '1;
    return m;
  endfunction

  function automatic logic [T3_AW-1:0] mask3(input logic [3:0] bits);
    logic [T3_AW-1:0] m;
    if (32'(bits) >= T3_AW) m = '1;
    else                    m = T3_AW'((32'd1 << bits) - 32'd1);
    return m;
  endfunction

  function automatic logic [T4_AW-1:0] mask4(input logic [3:0] bits);
    logic [T4_AW-1:0] m;
    if (32'(bits) >= T4_AW) m = '1;
    else                    m = T4_AW'((32'd1 << bits) - 32'd1);
    return m;
  endfunction

endpackage

[sv/multi_depth_prefix_cache_top.sv]
// top level of the multi-depth prefix cache
//
//  channel | direction | handshake          | contents
//  in_     | slave     | in_tvalid/tready   | tuser kind, tdata key/len/payload/origin
//  out_    | master    | out_tvalid/tready  | tdata depth/payload/origin
//  cfg_    | apb slave | psel/penable/pready| five control registers
//
// each word goes through accept, table and epoch read, epoch sum and tag compare,
// then update and result load. after reset a sweep zeroes every table and epoch
// counter; a clear word starts a sweep over the tag tables. no word is taken
// meanwhile. a waiting result holds only the last phase; the next word is accepted
// meanwhile.
module multi_depth_prefix_cache_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // key, key_len, entry_payload, entry_origin, zero pad
  input  logic [2:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // hit_depth, hit_payload, hit_origin, zero pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import mdpc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  logic [2:0]              hit_depth;
  logic [PAYLOAD_BITS-1:0] hit_payload;
  logic [1:0]              hit_origin;

  mdpc_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  mdpc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .stat, .cmd
  );

  mdpc_dp u_dp (
    .clk, .rst_n, .cmd, .cfg,
    .in_kind    (in_tuser),
    .in_key     (in_tdata[31:0]),
    .in_key_len (in_tdata[34:32]),
    .in_payload (in_tdata[98:35]),
    .in_origin  (in_tdata[100:99]),
    .stat,
    .hit_depth, .hit_payload, .hit_origin
  );

  assign out_tdata = {3'd0, hit_origin, hit_payload, hit_depth};

endmodule

[sv/mdpc_cfg.sv]
// configuration register file behind the apb-style port
module mdpc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output mdpc_pkg::cfg_t      cfg
);
  import mdpc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_T2_BITS: cfg_nxt.t2_bits = cfg_pwdata[4:0];
        REG_T3_EN:   cfg_nxt.t3_en   = cfg_pwdata[0];
        REG_T3_BITS: cfg_nxt.t3_bits = cfg_pwdata[3:0];
        REG_T4_EN:   cfg_nxt.t4_en   = cfg_pwdata[0];
        REG_T4_BITS: cfg_nxt.t4_bits = cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_T2_BITS: cfg_prdata = {27'd0, cfg_r.t2_bits};
      REG_T3_EN:   cfg_prdata = {31'd0, cfg_r.t3_en};
      REG_T3_BITS: cfg_prdata = {28'd0, cfg_r.t3_bits};
      REG_T4_EN:   cfg_prdata = {31'd0, cfg_r.t4_en};
      REG_T4_BITS: cfg_prdata = {28'd0, cfg_r.t4_bits};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.t2_bits <= 5'd16;
      cfg_r.t3_en   <= 1'b1;
      cfg_r.t3_bits <= 4'd12;
      cfg_r.t4_en   <= 1'b1;
      cfg_r.t4_bits <= 4'd12;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/mdpc_ctrl.sv]
// sequencer: handshakes, per-item phases and the table sweep
module mdpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  mdpc_pkg::stat_t stat,
  output mdpc_pkg::cmd_t  cmd
);
  import mdpc_pkg::*;

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [T2_AW-1:0] cnt_r, cnt_nxt;
  logic             full_r, full_nxt;
  logic             oval_r, oval_nxt;
  logic             fire;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  // result register free or draining this cycle
  assign fire       = (state_r == S_EXEC) && (!oval_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    full_nxt  = full_r;
    oval_nxt  = oval_r;
    if (oval_r && out_tready) oval_nxt = 1'b0;
    unique case (state_r)
      S_SWEEP: begin
        cnt_nxt = cnt_r + T2_AW'(1);
        if (cnt_r == '1) begin
          state_nxt = S_IDLE;
          full_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_EXEC;
      S_EXEC: begin
        if (fire) begin
          oval_nxt = 1'b1;
          if (stat.is_clear) begin
            state_nxt = S_SWEEP;
            cnt_nxt   = '0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_comb begin
    cmd.load       = (state_r == S_IDLE) && in_tvalid;
    cmd.rd         = (state_r == S_READ);
    cmd.eval       = (state_r == S_EVAL);
    cmd.exec       = fire;
    cmd.sweep      = (state_r == S_SWEEP);
    cmd.sweep_full = full_r;
    cmd.sweep_addr = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      cnt_r   <= '0;
      full_r  <= 1'b1;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      full_r  <= full_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

[sv/mdpc_dp.sv]
// datapath: prefix tables, epoch counters, hit check and result register
module mdpc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mdpc_pkg::cmd_t                    cmd,
  input  mdpc_pkg::cfg_t                    cfg,
  input  logic [2:0]                        in_kind,
  input  logic [31:0]                       in_key,
  input  logic [2:0]                        in_key_len,
  input  logic [mdpc_pkg::PAYLOAD_BITS-1:0] in_payload,
  input  logic [1:0]                        in_origin,
  output mdpc_pkg::stat_t                   stat,
  output logic [2:0]                        hit_depth,
  output logic [mdpc_pkg::PAYLOAD_BITS-1:0] hit_payload,
  output logic [1:0]                        hit_origin
);
  import mdpc_pkg::*;

  t2_entry_t   mem2 [TABLE2_DEPTH];
  t3_entry_t   mem3 [TABLE3_DEPTH];
  t4_entry_t   mem4 [TABLE4_DEPTH];
  logic [31:0] root_mem [ROOT_EPOCHS];
  logic [31:0] pfx_mem  [PREFIX_EPOCHS];

  logic [2:0]              kind_r;
  logic [31:0]             key_r;
  logic [2:0]              len_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [1:0]              org_r;

  t2_entry_t   rd2_r;
  t3_entry_t   rd3_r;
  t4_entry_t   rd4_r;
  logic [31:0] root_rd_r, pfx_rd_r;
  logic [31:0] glob_r, glob_nxt;
  logic [31:0] ep_r;
  logic        h2_r, h3_r, h4_r;

  logic [2:0]              dep_r;
  logic [PAYLOAD_BITS-1:0] opay_r;
  logic [1:0]              oorg_r;

  logic [T2_AW-1:0] idx2;
  logic [T3_AW-1:0] idx3;
  logic [T4_AW-1:0] idx4;
  logic [2:0]       lenc;
  logic             short_key;

  assign stat.is_clear = (kind_r == K_CLEAR);
  assign hit_depth     = dep_r;
  assign hit_payload   = opay_r;
  assign hit_origin    = oorg_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      len_r  <= in_key_len;
      pay_r  <= in_payload;
      org_r  <= in_origin;
    end
  end

  assign lenc      = (len_r > 3'd4) ? 3'd4 : len_r;
  assign short_key = (lenc < 3'd2);
  assign idx2      = key_r[T2_AW-1:0] & mask2(cfg.t2_bits);
  // folded index: prefix xor (prefix >> 16)
  assign idx3 = (key_r[T3_AW-1:0] ^ T3_AW'({8'd0, key_r[23:16]})) & mask3(cfg.t3_bits);
  assign idx4 = (key_r[T4_AW-1:0] ^ T4_AW'(key_r[31:16])) & mask4(cfg.t4_bits);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd2_r     <= mem2[idx2];
      rd3_r     <= mem3[idx3];
      rd4_r     <= mem4[idx4];
      root_rd_r <= root_mem[key_r[ROOT_AW-1:0]];
      pfx_rd_r  <= pfx_mem[key_r[PFX_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ep_r <= glob_r + root_rd_r + pfx_rd_r;
      h4_r <= cfg.t4_en && (lenc >= 3'd4) && rd4_r.valid && (rd4_r.tag == key_r);
      h3_r <= cfg.t3_en && (lenc >= 3'd3) && rd3_r.valid && (rd3_r.tag == key_r[23:0]);
      h2_r <= rd2_r.valid && ((cfg.t2_bits >= 5'd16) || (rd2_r.tag == key_r[15:0]));
    end
  end

  // result selection, deepest tag hit wins and a stale epoch is final
  logic [2:0]              sel_dep;
  logic [31:0]             sel_ep;
  logic [1:0]              sel_org;
  logic [PAYLOAD_BITS-1:0] sel_pay;
  logic                    hit;

  always_comb begin
    priority if (h4_r) begin
      sel_dep = 3'd4; sel_ep = rd4_r.epoch; sel_org = rd4_r.origin; sel_pay = rd4_r.payload;
    end else if (h3_r) begin
      sel_dep = 3'd3; sel_ep = rd3_r.epoch; sel_org = rd3_r.origin; sel_pay = rd3_r.payload;
    end else if (h2_r) begin
      sel_dep = 3'd2; sel_ep = rd2_r.epoch; sel_org = rd2_r.origin; sel_pay = rd2_r.payload;
    end else begin
      sel_dep = 3'd0; sel_ep = 32'd0; sel_org = 2'd0; sel_pay = '0;
    end
    hit = (kind_r == K_LOOKUP) && !short_key && (sel_dep != 3'd0) && (sel_ep == ep_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      dep_r  <= hit ? sel_dep : 3'd0;
      opay_r <= hit ? sel_pay : '0;
      oorg_r <= hit ? sel_org : 2'd0;
    end
  end

  // puts
  logic do_p2, do_p3, do_p4;
  logic put_all;

  assign put_all = (kind_r == K_PUT_ALL) && !short_key;
  assign do_p4 = cmd.exec && ((put_all && cfg.t4_en && lenc >= 3'd4) ||
                 ((kind_r == K_PUT_DEPTH) && len_r == 3'd4 && cfg.t4_en));
  assign do_p3 = cmd.exec && ((put_all && cfg.t3_en && lenc >= 3'd3) ||
                 ((kind_r == K_PUT_DEPTH) && len_r == 3'd3 && cfg.t3_en));
  assign do_p2 = cmd.exec && (put_all || ((kind_r == K_PUT_DEPTH) && len_r == 3'd2));

  t2_entry_t wd2;
  t3_entry_t wd3;
  t4_entry_t wd4;

  always_comb begin
    wd4.valid   = 1'b1;
    wd4.tag     = key_r;
    wd4.origin  = org_r;
    wd4.epoch   = ep_r;
    wd4.payload = pay_r;
    wd3.valid   = 1'b1;
    wd3.tag     = key_r[23:0];
    wd3.origin  = org_r | (rd3_r.valid ? rd3_r.origin : 2'd0);
    wd3.epoch   = ep_r;
    wd3.payload = pay_r;
    wd2.valid   = 1'b1;
    wd2.tag     = key_r[15:0];
    wd2.origin  = org_r | (rd2_r.valid ? rd2_r.origin : 2'd0);
    wd2.epoch   = ep_r;
    wd2.payload = pay_r;
    if (cmd.sweep) begin
      wd2 = '0;
      wd3 = '0;
      wd4 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep)  mem2[cmd.sweep_addr] <= wd2;
    else if (do_p2) mem2[idx2] <= wd2;
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep)  mem3[cmd.sweep_addr[T3_AW-1:0]] <= wd3;
    else if (do_p3) mem3[idx3] <= wd3;
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep)  mem4[cmd.sweep_addr[T4_AW-1:0]] <= wd4;
    else if (do_p4) mem4[idx4] <= wd4;
  end

  // prefix and root epoch counters, zeroed only by the sweep that follows reset
  always_ff @(posedge clk) begin
    if (cmd.sweep && cmd.sweep_full)
      pfx_mem[cmd.sweep_addr[PFX_AW-1:0]] <= 32'd0;
    else if (cmd.exec && (kind_r == K_INV_PFX) && !short_key)
      pfx_mem[key_r[PFX_AW-1:0]] <= pfx_rd_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep && cmd.sweep_full)
      root_mem[cmd.sweep_addr[ROOT_AW-1:0]] <= 32'd0;
    else if (cmd.exec && (kind_r == K_INV_ROOT))
      root_mem[key_r[ROOT_AW-1:0]] <= root_rd_r + 32'd1;
  end

  assign glob_nxt = (cmd.exec && (kind_r == K_INV_ALL)) ? glob_r + 32'd1 : glob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) glob_r <= 32'd0;
    else        glob_r <= glob_nxt;
  end

endmodule

[sv/mdpc_chk.sv]
// port-level checks for the prefix cache, bound to the top level
module mdpc_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata
);

  // one word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in flight");

  a_depth_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] == 3'd0 || out_tdata[2:0] == 3'd2 ||
                    out_tdata[2:0] == 3'd3 || out_tdata[2:0] == 3'd4))
    else $error("bad hit depth");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == 3'd0 |-> out_tdata[71:3] == 69'd0)
    else $error("miss carries nonzero payload or origin");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind multi_depth_prefix_cache_top mdpc_chk u_mdpc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[dv/multi_depth_prefix_cache_top_test.sv]
// testbench for the multi-depth prefix cache: a shadow cache model checks every result word
`timescale 1ns / 1ps

module multi_depth_prefix_cache_top_test;
  import mdpc_pkg::*;

  localparam logic [2:0] K_UNUSED = 3'd7;

  typedef struct {
    bit          valid;
    bit [31:0]   tag;
    bit [1:0]    origin;
    bit [31:0]   epoch;
    bit [63:0]   payload;
  } slot_t;

  class cache_scoreboard;
    slot_t     two[TABLE2_DEPTH];
    slot_t     three[TABLE3_DEPTH];
    slot_t     four[TABLE4_DEPTH];
    bit [31:0] ep_global;
    bit [31:0] ep_root[ROOT_EPOCHS];
    bit [31:0] ep_prefix[PREFIX_EPOCHS];
    bit [4:0]  t2_bits = 16;
    bit        t3_en = 1;
    bit [3:0]  t3_bits = 12;
    bit        t4_en = 1;
    bit [3:0]  t4_bits = 12;
    bit [68:0] pending[$];
    int        mismatches;
    int        unexpected;
    int        hits;
    int        lookups;

    function void set_reg(bit [2:0] idx, bit [31:0] val);
      case (idx)
        REG_T2_BITS: t2_bits = val[4:0];
        REG_T3_EN:   t3_en = val[0];
        REG_T3_BITS: t3_bits = val[3:0];
        REG_T4_EN:   t4_en = val[0];
        REG_T4_BITS: t4_bits = val[3:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] small_mask(bit [3:0] bits);
      return ((32'd1 << bits) - 32'd1) & (TABLE3_DEPTH - 1);
    endfunction

    function bit [31:0] two_mask();
      bit [4:0] b;
      b = t2_bits < 14 ? 5'd14 : (t2_bits > 16 ? 5'd16 : t2_bits);
      return ((32'd1 << b) - 32'd1) & (TABLE2_DEPTH - 1);
    endfunction

    function bit [31:0] epoch_of(bit [31:0] key);
      return ep_global + ep_root[key[7:0]] + ep_prefix[key[15:0]];
    endfunction

    function void store(int depth, bit [31:0] key, bit [63:0] pay, bit [1:0] org,
                        bit [31:0] ep);
      int i;
      bit [31:0] p;
      if (depth == 4) begin
        i = (key ^ (key >> 16)) & ((32'd1 << t4_bits) - 1) & (TABLE4_DEPTH - 1);
        four[i] = '{1'b1, key, org, ep, pay};
      end else if (depth == 3) begin
        p = key & 32'hFFFFFF;
        i = (p ^ (p >> 16)) & small_mask(t3_bits);
        if (three[i].valid) org |= three[i].origin;
        three[i] = '{1'b1, p, org, ep, pay};
      end else begin
        p = key & 32'hFFFF;
        i = p & two_mask();
        if (two[i].valid) org |= two[i].origin;
        two[i] = '{1'b1, p, org, ep, pay};
      end
    endfunction

    function void note_word(bit [2:0] kind, bit [31:0] key, bit [2:0] raw_len,
                            bit [63:0] pay, bit [1:0] org);
      bit [2:0]  len;
      bit [2:0]  hd;
      bit [63:0] hp;
      bit [1:0]  ho;
      bit [31:0] ep;
      bit [31:0] p;
      int        i;
      slot_t     s;
      bit        found;
      len = raw_len > 4 ? 3'd4 : raw_len;
      hd = 0; hp = 0; ho = 0;
      ep = epoch_of(key);
      case (kind)
        K_LOOKUP: if (len >= 2) begin
          lookups++;
          found = 0;
          if (t4_en && len >= 4) begin
            i = (key ^ (key >> 16)) & ((32'd1 << t4_bits) - 1) & (TABLE4_DEPTH - 1);
            if (four[i].valid && four[i].tag == key) begin
              found = 1; hd = 4; s = four[i];
            end
          end
          if (!found && t3_en && len >= 3) begin
            p = key & 32'hFFFFFF;
            i = (p ^ (p >> 16)) & small_mask(t3_bits);
            if (three[i].valid && three[i].tag == p) begin
              found = 1; hd = 3; s = three[i];
            end
          end
          if (!found) begin
            p = key & 32'hFFFF;
            i = p & two_mask();
            if (two[i].valid && (t2_bits >= 16 || two[i].tag == p)) begin
              found = 1; hd = 2; s = two[i];
            end
          end
          // a stale tag hit ends the search as a miss
          if (!found || s.epoch != ep) hd = 0;
          else begin
            hp = s.payload; ho = s.origin; hits++;
          end
        end
        K_PUT_ALL: if (len >= 2) begin
          if (t4_en && len >= 4) store(4, key, pay, org, ep);
          if (t3_en && len >= 3) store(3, key, pay, org, ep);
          store(2, key, pay, org, ep);
        end
        K_PUT_DEPTH: begin
          if (raw_len == 4 && t4_en) store(4, key, pay, org, ep);
          else if (raw_len == 3 && t3_en) store(3, key, pay, org, ep);
          else if (raw_len == 2) store(2, key, pay, org, ep);
        end
        K_INV_PFX: if (len >= 2) ep_prefix[key[15:0]] += 1;
        K_INV_ROOT: ep_root[key[7:0]] += 1;
        K_INV_ALL: ep_global += 1;
        K_CLEAR: begin
          foreach (two[j]) two[j].valid = 0;
          foreach (three[j]) three[j].valid = 0;
          foreach (four[j]) four[j].valid = 0;
        end
        default: ;
      endcase
      pending.push_back({ho, hp, hd});
    endfunction

    function void check_word(bit [71:0] word);
      bit [68:0] want;
      if (pending.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result word %h", word[68:0]);
        return;
      end
      want = pending.pop_front();
      if (want[2:0] != word[2:0] || want[66:3] != word[66:3] ||
          want[68:67] != word[68:67]) begin
        mismatches++;
        if (mismatches + unexpected <= 10)
          $display("mismatch: depth %0d/%0d payload %h/%h origin %0d/%0d (exp/act)",
                   want[2:0], word[2:0], want[66:3], word[66:3],
                   want[68:67], word[68:67]);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // key, key_len, entry_payload, entry_origin, zero pad
  logic [2:0]   in_tuser;   // kind
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;  // hit_depth, hit_payload, hit_origin, zero pad
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  multi_depth_prefix_cache_top dut (.*);

  cache_scoreboard sb;
  int send_gap_pct;
  int recv_gap_pct;
  bit [31:0] key_pool[24];
  int clears_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("multi_depth_prefix_cache_top_test NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  task automatic write_reg(bit [2:0] idx, bit [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 5'(idx) << 2; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // in_tvalid stays high between back-to-back words
  task automatic send_word(bit [2:0] kind, bit [31:0] key, bit [2:0] len,
                           bit [63:0] pay, bit [1:0] org);
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {3'b0, org, pay, len, key};
    do @(posedge clk); while (!in_tready);
    sb.note_word(kind, key, len, pay, org);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic idle_input();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic bit [63:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  task automatic random_word();
    bit [2:0]  kind;
    bit [31:0] key;
    bit [2:0]  len;
    int        r;
    r = $urandom_range(99);
    key = key_pool[$urandom_range(23)];
    if ($urandom_range(9) == 0) key = $urandom;
    else if ($urandom_range(5) == 0) key[31:24] = 8'($urandom);
    len = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 2));
    if (r < 42) kind = K_LOOKUP;
    else if (r < 64) kind = K_PUT_ALL;
    else if (r < 80) kind = K_PUT_DEPTH;
    else if (r < 88) kind = K_INV_PFX;
    else if (r < 93) kind = K_INV_ROOT;
    else if (r < 96) kind = K_INV_ALL;
    else if (r < 98) kind = K_UNUSED;
    else if (clears_left > 0 && $urandom_range(15) == 0) begin
      kind = K_CLEAR; clears_left--;
    end else kind = K_LOOKUP;
    send_word(kind, key, len, rand_payload(), 2'($urandom));
  endtask

  task automatic directed();
    bit [31:0] k;
    k = 32'h4433_2211;
    send_word(K_LOOKUP, k, 4, '1, 3);
    send_word(K_PUT_ALL, k, 4, '1, 1);
    send_word(K_LOOKUP, k, 4, 0, 0);
    send_word(K_LOOKUP, k, 7, 0, 0);
    send_word(K_PUT_DEPTH, k, 3, 64'h0123_4567_89AB_CDEF, 2);
    send_word(K_LOOKUP, k ^ 32'hFF00_0000, 4, 0, 0);
    send_word(K_PUT_DEPTH, 32'hFFFF_FFFF, 2, 0, 0);
    send_word(K_PUT_DEPTH, 32'hFFFF_FFFF, 5, '1, 3);
    send_word(K_PUT_ALL, 32'h0, 1, '1, 3);
    send_word(K_LOOKUP, 32'hFFFF_FFFF, 2, 0, 0);
    send_word(K_LOOKUP, k, 1, 0, 0);
    send_word(K_INV_PFX, k, 0, 0, 0);
    send_word(K_INV_PFX, k, 2, 0, 0);
    // stale tag at depth 4 must not fall back
    send_word(K_PUT_DEPTH, 32'h5533_2211, 2, 64'h55, 1);
    send_word(K_LOOKUP, k, 4, 0, 0);
    send_word(K_INV_ROOT, 32'hFFFF_FFFF, 0, 0, 0);
    send_word(K_LOOKUP, 32'hFFFF_FFFF, 4, 0, 0);
    send_word(K_PUT_ALL, 32'h0000_0000, 4, 64'h1, 0);
    send_word(K_INV_ALL, 0, 0, 0, 0);
    send_word(K_LOOKUP, 32'h0000_0000, 4, 0, 0);
    send_word(K_UNUSED, 32'hFFFF_FFFF, 7, '1, 3);
    send_word(K_PUT_ALL, 32'h0000_0000, 6, 64'h2, 2);
    send_word(K_CLEAR, 0, 0, 0, 0);
    send_word(K_LOOKUP, 32'h0000_0000, 4, 0, 0);
  endtask

  initial begin
    bit [31:0] cfgs[6][5];
    int        per_phase;
    sb = new();
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    send_gap_pct = 6; recv_gap_pct = 46;
    clears_left = 4;
    cfgs = '{'{16, 1, 12, 1, 12}, '{14, 0, 0, 0, 0}, '{15, 1, 3, 1, 2},
             '{31, 1, 15, 0, 15}, '{0, 0, 5, 1, 1}, '{16, 1, 1, 1, 0}};
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom;
      if (i % 3 == 1) key_pool[i][15:0] = key_pool[i - 1][15:0];
      if (i % 3 == 2) key_pool[i][23:0] = key_pool[i - 1][23:0];
    end
    repeat (2) @(posedge clk);
    rst_n <= 1;
    for (int r = 0; r < 5; r++) write_reg(3'(r), cfgs[0][r]);
    directed();
    per_phase = 1900 / 6;
    for (int ph = 0; ph < 6; ph++) begin
      idle_input();
      drain();
      for (int r = 0; r < 5; r++) write_reg(3'(r), cfgs[ph][r]);
      for (int n = 0; n < per_phase; n++) begin
        if (n == per_phase / 3) begin
          send_gap_pct = 46; recv_gap_pct = 6;
        end else if (n == 2 * per_phase / 3) begin
          send_gap_pct = 0; recv_gap_pct = 0;
        end
        if (ph == 2 && n == per_phase / 2) begin
          idle_input();
          while (sb.pending.size() != 0) @(posedge clk);
        end
        random_word();
      end
      send_gap_pct = 6; recv_gap_pct = 46;
    end
    idle_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d lookups (%0d hits) over 6 register settings, %0d clears",
             sb.lookups, sb.hits, 5 - clears_left);
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending.size() == 0)
      $display("multi_depth_prefix_cache_top_test OK");
    else
      $display("multi_depth_prefix_cache_top_test NOT OK");
    $finish;
  end

endmodule

[multi_depth_prefix_cache_top.f]
sv/mdpc_pkg.sv
sv/mdpc_cfg.sv
sv/mdpc_ctrl.sv
sv/mdpc_dp.sv
sv/multi_depth_prefix_cache_top.sv
sv/mdpc_chk.sv
dv/multi_depth_prefix_cache_top_test.sv
